/* rtl/core/rlf_pkg.sv */
// Shared types, codes and the LFSR step for the random LED fade block.
package rlf_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_START = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_STOP  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_ACTIVE_SLOTS   = 3'd0,
    REG_SYNC_SPREAD    = 3'd1,
    REG_PEAK_LEVEL     = 3'd2,
    REG_FIRST_LED      = 3'd3,
    REG_SPAN_LENGTH    = 3'd4,
    REG_FADE_COLOR     = 3'd5,
    REG_USE_FADE_COLOR = 3'd6,
    REG_RANDOM_SEED    = 3'd7
  } reg_idx_t;

  typedef enum logic [16:0] {
    ST_CLR   = 17'h00001,
    ST_IDLE  = 17'h00002,
    ST_SNEXT = 17'h00004,
    ST_TCHK  = 17'h00008,
    ST_TRD   = 17'h00010,
    ST_TNEXT = 17'h00020,
    ST_PCHK  = 17'h00040,
    ST_PRD   = 17'h00080,
    ST_PNEXT = 17'h00100,
    ST_FBEG  = 17'h00200,
    ST_FDRAW = 17'h00400,
    ST_FDIV  = 17'h00800,
    ST_FHELD = 17'h01000,
    ST_ASN   = 17'h02000,
    ST_ARD   = 17'h04000,
    ST_ADIV  = 17'h08000,
    ST_DONE  = 17'h10000
  } state_t;

  localparam logic [15:0] LFSR_TAPS  = 16'hB400;
  localparam logic [15:0] RESET_SEED = 16'd44257;

  function automatic logic [15:0] lfsr_step(input logic [15:0] x);
    lfsr_step = {1'b0, x[15:1]} ^ (x[0] ? LFSR_TAPS : 16'd0);
  endfunction

endpackage

/* rtl/core/rlf_divu.sv */
// Radix-2 restoring divider, remainder only, one bit per cycle.
module rlf_divu import rlf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        div_start,
  input  logic [15:0] div_a,
  input  logic [15:0] div_b,
  output logic        div_done,
  output logic [15:0] div_rem
);

  logic [15:0] rem_r, quo_r, den_r;
  logic [3:0]  cnt_r;
  logic        run_r, done_r;
  logic [16:0] trial;
  logic [15:0] rem_nxt;

  always_comb begin
    trial = {rem_r, quo_r[15]};
    if (trial >= {1'b0, den_r}) begin
      rem_nxt = 16'(trial - {1'b0, den_r});
    end else begin
      rem_nxt = trial[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (div_start) begin
        rem_r <= '0;
        quo_r <= div_a;
        den_r <= div_b;
        cnt_r <= '0;
        run_r <= 1'b1;
      end else if (run_r) begin
        rem_r <= rem_nxt;
        quo_r <= {quo_r[14:0], 1'b0};
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign div_done = done_r;
  assign div_rem  = rem_r;

endmodule

/* rtl/core/random_led_fade_effect.sv */
// Random LED fade effect: pixel store, fade slots, sequencer and shared divider.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+-----------------------------
//  input   | in_command, in_pixel_*                  | start & !busy
//  result  | out_led_*, out_last_update              | out_valid, one cycle, no stall
//  config  | cfg_index, cfg_data                     | cfg_valid & cfg_ready
//
// After reset a clearing pass zeroes the pixel store while busy is high.
// Tick and stop walk the slots and end in a closing state; every free-LED search
// does, per random try, a draw, a wait on the shared divider and a walk over the
// slot table; a nonzero sync spread adds a further divider pass for the start wait.
// Results leave one beat behind the update that makes them, so the final beat can
// carry last_update. The receiver cannot stall.
module random_led_fade_effect import rlf_pkg::*; #(
  parameter int NUM_LEDS  = 256,
  parameter int MAX_SLOTS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_pixel_index,
  input  logic [7:0]  in_pixel_level,
  input  logic [31:0] in_pixel_color,
  output logic        out_valid,
  output logic [7:0]  out_led_position,
  output logic [7:0]  out_led_level,
  output logic [31:0] out_led_color,
  output logic        out_last_update,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int LW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam int PW = LW + 1;
  localparam int KW = LW + 2;
  localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int SW = $clog2(MAX_SLOTS + 1);

  // configuration
  logic [5:0]  active_r;
  logic [15:0] sync_r;
  logic [7:0]  peak_r;
  logic [7:0]  first_r;
  logic [8:0]  span_r;
  logic [31:0] fcol_r;
  logic        use_r;
  logic [15:0] seed_r;

  // latched at start
  logic          running_r;
  logic [LW-1:0] run_start_r;
  logic [PW-1:0] run_len_r;
  logic [SW-1:0] run_count_r;
  logic [15:0]   run_sync_r;
  logic [7:0]    run_peak_r;
  logic [31:0]   run_color_r;
  logic          run_use_r;

  // pixel store
  logic [7:0]  store_level_r [NUM_LEDS];
  logic [31:0] store_color_r [NUM_LEDS];
  logic [7:0]  rd_level_r;
  logic [31:0] rd_color_r;
  logic          mem_we, mem_re;
  logic [LW-1:0] mem_wa, mem_ra;
  logic [7:0]    mem_wl;
  logic [31:0]   mem_wc;

  // slot table
  logic [LW-1:0]  slot_led_r   [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] slot_valid_r;
  logic [7:0]     slot_level_r [MAX_SLOTS];
  logic [15:0]    slot_wait_r  [MAX_SLOTS];
  logic [7:0]     slot_slvl_r  [MAX_SLOTS];
  logic [31:0]    slot_scol_r  [MAX_SLOTS];

  state_t        state_r;
  logic [LW-1:0] clr_r;
  logic [IW-1:0] i_r;
  logic [SW-1:0] j_r;
  logic [KW-1:0] k_r;
  logic [PW-1:0] cand_r;
  logic          lin_r;
  logic          ctx_tick_r;
  logic [15:0]   lfsr_r;

  // result staging
  logic        pend_v_r;
  logic [7:0]  pend_pos_r, pend_lvl_r;
  logic [31:0] pend_col_r;
  logic        out_valid_r, out_last_r;
  logic [7:0]  out_pos_r, out_lvl_r;
  logic [31:0] out_col_r;

  // shared divider
  logic        div_start, div_done;
  logic [15:0] div_a, div_b, div_rem;

  rlf_divu u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .div_start(div_start),
    .div_a    (div_a),
    .div_b    (div_b),
    .div_done (div_done),
    .div_rem  (div_rem)
  );

  logic accept;
  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  // start parameters
  logic [31:0] c_start, c_room, c_len, c_cnt;
  always_comb begin
    c_start = ({24'd0, first_r} < 32'(NUM_LEDS)) ? {24'd0, first_r} : 32'd0;
    c_room  = 32'(NUM_LEDS) - c_start;
    c_len   = ({23'd0, span_r} > c_room) ? c_room : {23'd0, span_r};
    c_cnt   = {26'd0, active_r};
    if (c_cnt > c_len) c_cnt = c_len;
    if (c_cnt > 32'(MAX_SLOTS)) c_cnt = 32'(MAX_SLOTS);
    if (c_cnt > 32'd32) c_cnt = 32'd32;
  end

  // current slot view
  logic [LW-1:0] s_led;
  logic [7:0]    s_lvl, s_slvl;
  logic [31:0]   s_scol;
  logic [15:0]   s_wait;
  logic          s_valid, t_restore;
  logic [7:0]    t_lvl_new;
  logic [31:0]   t_col_new, p_col_new;
  logic [IW-1:0] jx;
  logic          hit, j_end;
  logic [SW-1:0] i_inc;
  logic          i_last;
  logic [PW-1:0] run_end;

  always_comb begin
    s_led     = slot_led_r[i_r];
    s_lvl     = slot_level_r[i_r];
    s_slvl    = slot_slvl_r[i_r];
    s_scol    = slot_scol_r[i_r];
    s_wait    = slot_wait_r[i_r];
    s_valid   = slot_valid_r[i_r];
    t_restore = ({1'b0, s_lvl} <= ({1'b0, s_slvl} + 9'd1));
    t_lvl_new = t_restore ? s_slvl : s_lvl;
    if (run_use_r) begin
      t_col_new = t_restore ? s_scol : run_color_r;
    end else begin
      t_col_new = rd_color_r;
    end
    p_col_new = run_use_r ? s_scol : rd_color_r;
    jx        = j_r[IW-1:0];
    hit       = slot_valid_r[jx] && (slot_led_r[jx] == cand_r[LW-1:0]);
    j_end     = (j_r == run_count_r);
    i_inc     = SW'(i_r) + SW'(1);
    i_last    = (i_inc == run_count_r);
    run_end   = PW'(run_start_r) + run_len_r;
  end

  // store port control
  always_comb begin
    mem_we = 1'b0;
    mem_wa = s_led;
    mem_wl = '0;
    mem_wc = '0;
    mem_re = 1'b0;
    mem_ra = s_led;
    unique case (state_r)
      ST_CLR: begin
        mem_we = 1'b1;
        mem_wa = clr_r;
      end
      ST_IDLE: begin
        if (accept && (in_command == CMD_LOAD) &&
            ({24'd0, in_pixel_index} < 32'(NUM_LEDS))) begin
          mem_we = 1'b1;
          mem_wa = LW'(in_pixel_index);
          mem_wl = in_pixel_level;
          mem_wc = in_pixel_color;
        end
      end
      ST_TCHK, ST_PCHK: mem_re = 1'b1;
      ST_TRD: begin
        mem_we = 1'b1;
        mem_wl = t_lvl_new;
        mem_wc = t_col_new;
      end
      ST_PRD: begin
        mem_we = 1'b1;
        mem_wl = s_slvl;
        mem_wc = p_col_new;
      end
      ST_ASN: begin
        mem_re = 1'b1;
        mem_ra = cand_r[LW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_level_r[mem_wa] <= mem_wl;
      store_color_r[mem_wa] <= mem_wc;
    end
    if (mem_re) begin
      rd_level_r <= store_level_r[mem_ra];
      rd_color_r <= store_color_r[mem_ra];
    end
  end

  // divider feed
  always_comb begin
    div_start = 1'b0;
    div_a     = lfsr_step(lfsr_r);
    div_b     = 16'(run_len_r);
    if (state_r == ST_FDRAW) begin
      div_start = 1'b1;
    end else if ((state_r == ST_ARD) && (run_sync_r != 16'd0)) begin
      div_start = 1'b1;
      div_b     = run_sync_r;
    end
  end

  // result beat produced this cycle
  logic        push;
  logic [7:0]  push_lvl;
  logic [31:0] push_col;
  always_comb begin
    push     = (state_r == ST_TRD) || (state_r == ST_PRD);
    push_lvl = (state_r == ST_TRD) ? t_lvl_new : s_slvl;
    push_col = (state_r == ST_TRD) ? t_col_new : p_col_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 6'd8;
      sync_r      <= '0;
      peak_r      <= 8'd255;
      first_r     <= '0;
      span_r      <= 9'd256;
      fcol_r      <= '0;
      use_r       <= 1'b0;
      seed_r      <= RESET_SEED;
      running_r   <= 1'b0;
      state_r     <= ST_CLR;
      clr_r       <= '0;
      slot_valid_r <= '0;
      lfsr_r      <= RESET_SEED;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      run_count_r <= '0;
    end else begin
      out_valid_r <= 1'b0;

      if (cfg_valid) begin
        unique case (reg_idx_t'(cfg_index))
          REG_ACTIVE_SLOTS:   active_r <= cfg_data[5:0];
          REG_SYNC_SPREAD:    sync_r   <= cfg_data[15:0];
          REG_PEAK_LEVEL:     peak_r   <= cfg_data[7:0];
          REG_FIRST_LED:      first_r  <= cfg_data[7:0];
          REG_SPAN_LENGTH:    span_r   <= cfg_data[8:0];
          REG_FADE_COLOR:     fcol_r   <= cfg_data;
          REG_USE_FADE_COLOR: use_r    <= cfg_data[0];
          REG_RANDOM_SEED:    seed_r   <= cfg_data[15:0];
          default: ;
        endcase
      end

      if (push) begin
        if (pend_v_r) begin
          out_valid_r <= 1'b1;
          out_last_r  <= 1'b0;
          out_pos_r   <= pend_pos_r;
          out_lvl_r   <= pend_lvl_r;
          out_col_r   <= pend_col_r;
        end
        pend_v_r   <= 1'b1;
        pend_pos_r <= 8'(s_led);
        pend_lvl_r <= push_lvl;
        pend_col_r <= push_col;
      end

      unique case (state_r)
        ST_CLR: begin
          clr_r <= clr_r + LW'(1);
          if (32'(clr_r) == 32'(NUM_LEDS - 1)) state_r <= ST_IDLE;
        end
        ST_IDLE: begin
          if (accept) begin
            unique case (cmd_t'(in_command))
              CMD_LOAD: ;
              CMD_START: begin
                if (!running_r) begin
                  running_r    <= 1'b1;
                  run_start_r  <= LW'(c_start);
                  run_len_r    <= PW'(c_len);
                  run_count_r  <= SW'(c_cnt);
                  run_sync_r   <= sync_r;
                  run_peak_r   <= peak_r;
                  run_color_r  <= fcol_r;
                  run_use_r    <= use_r;
                  lfsr_r       <= (seed_r != 16'd0) ? seed_r : 16'd1;
                  slot_valid_r <= '0;
                  i_r          <= '0;
                  ctx_tick_r   <= 1'b0;
                  if (c_cnt != 32'd0) state_r <= ST_FBEG;
                end
              end
              CMD_TICK: begin
                if (running_r && (run_count_r != '0)) begin
                  i_r     <= '0;
                  state_r <= ST_TCHK;
                end
              end
              CMD_STOP: begin
                if (running_r) begin
                  running_r <= 1'b0;
                  i_r       <= '0;
                  if (run_count_r != '0) state_r <= ST_PCHK;
                end
              end
              default: ;
            endcase
          end
        end
        ST_SNEXT: begin
          if (i_last) begin
            state_r <= ST_IDLE;
          end else begin
            i_r     <= i_r + IW'(1);
            state_r <= ST_FBEG;
          end
        end
        ST_TCHK: begin
          if (s_wait != 16'd0) begin
            slot_wait_r[i_r] <= s_wait - 16'd1;
            state_r <= ST_TNEXT;
          end else if (!s_valid) begin
            state_r <= ST_TNEXT;
          end else begin
            state_r <= ST_TRD;
          end
        end
        ST_TRD: begin
          slot_level_r[i_r] <= (s_lvl != 8'd0) ? (s_lvl - 8'd1) : 8'd0;
          if (t_restore) begin
            ctx_tick_r <= 1'b1;
            state_r    <= ST_FBEG;
          end else begin
            state_r <= ST_TNEXT;
          end
        end
        ST_TNEXT: begin
          if (i_last) begin
            state_r <= ST_DONE;
          end else begin
            i_r     <= i_r + IW'(1);
            state_r <= ST_TCHK;
          end
        end
        ST_PCHK: state_r <= s_valid ? ST_PRD : ST_PNEXT;
        ST_PRD: begin
          slot_valid_r[i_r] <= 1'b0;
          state_r <= ST_PNEXT;
        end
        ST_PNEXT: begin
          if (i_last) begin
            state_r <= ST_DONE;
          end else begin
            i_r     <= i_r + IW'(1);
            state_r <= ST_PCHK;
          end
        end
        ST_FBEG: begin
          k_r   <= '0;
          lin_r <= 1'b0;
          if (run_len_r == '0) begin
            if (!ctx_tick_r) slot_wait_r[i_r] <= '0;
            state_r <= ctx_tick_r ? ST_TNEXT : ST_SNEXT;
          end else begin
            state_r <= ST_FDRAW;
          end
        end
        ST_FDRAW: begin
          lfsr_r  <= lfsr_step(lfsr_r);
          state_r <= ST_FDIV;
        end
        ST_FDIV: begin
          if (div_done) begin
            cand_r  <= PW'(run_start_r) + PW'(div_rem);
            j_r     <= '0;
            state_r <= ST_FHELD;
          end
        end
        ST_FHELD: begin
          if (j_end) begin
            state_r <= ST_ASN;
          end else if (hit) begin
            j_r <= '0;
            if (!lin_r) begin
              if ((k_r + KW'(1)) == {run_len_r, 1'b0}) begin
                lin_r  <= 1'b1;
                cand_r <= PW'(run_start_r);
              end else begin
                k_r     <= k_r + KW'(1);
                state_r <= ST_FDRAW;
              end
            end else if ((cand_r + PW'(1)) == run_end) begin
              // no free LED anywhere in the span
              if (!ctx_tick_r) slot_wait_r[i_r] <= '0;
              state_r <= ctx_tick_r ? ST_TNEXT : ST_SNEXT;
            end else begin
              cand_r <= cand_r + PW'(1);
            end
          end else begin
            j_r <= j_r + SW'(1);
          end
        end
        ST_ASN: state_r <= ST_ARD;
        ST_ARD: begin
          slot_led_r[i_r]   <= cand_r[LW-1:0];
          slot_valid_r[i_r] <= 1'b1;
          slot_level_r[i_r] <= run_peak_r;
          slot_slvl_r[i_r]  <= rd_level_r;
          slot_scol_r[i_r]  <= rd_color_r;
          if (run_sync_r != 16'd0) begin
            lfsr_r  <= lfsr_step(lfsr_r);
            state_r <= ST_ADIV;
          end else begin
            slot_wait_r[i_r] <= '0;
            state_r <= ctx_tick_r ? ST_TNEXT : ST_SNEXT;
          end
        end
        ST_ADIV: begin
          if (div_done) begin
            slot_wait_r[i_r] <= div_rem;
            state_r <= ctx_tick_r ? ST_TNEXT : ST_SNEXT;
          end
        end
        ST_DONE: begin
          if (pend_v_r) begin
            out_valid_r <= 1'b1;
            out_last_r  <= 1'b1;
            out_pos_r   <= pend_pos_r;
            out_lvl_r   <= pend_lvl_r;
            out_col_r   <= pend_col_r;
          end
          pend_v_r <= 1'b0;
          state_r  <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_led_position = out_pos_r;
  assign out_led_level    = out_lvl_r;
  assign out_led_color    = out_col_r;
  assign out_last_update  = out_last_r;

endmodule
